/* rtl/core/djp_pkg.sv */
// Shared types, constants and helper functions of the dipole beam Jones block.
`timescale 1ns / 1ps
`default_nettype none
package djp_pkg;

   localparam int ANGLE_W       = 30;
   localparam int REDUCE_STEPS  = 6;
   localparam int CORDIC_STEPS  = 24;

   localparam logic [22:0]        HALF_PI_LIMIT = 23'd1647100;
   localparam logic signed [31:0] HALF_PI_Q20   = 32'sd1647099;
   localparam logic signed [31:0] PI_Q20        = 32'sd3294199;
   localparam logic signed [31:0] TWO_PI_Q20    = 32'sd6588397;
   localparam logic signed [33:0] CORDIC_START  = 34'sd652032874;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [2:0] {
      CSR_NUM_HARMONICS = 3'd0,
      CSR_THETA_TERMS   = 3'd1,
      CSR_FREQ_TERMS    = 3'd2,
      CSR_FREQ_CENTER   = 3'd3,
      CSR_INV_RANGE     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      CR_IDLE, CR_REDUCE, CR_FOLD, CR_ROTATE, CR_DONE
   } cr_state_type;

   typedef enum logic [4:0] {
      S_IDLE, S_NORM_A, S_NORM_B, S_NORM_C, S_ROW_RD, S_ROW_DAT, S_FMUL, S_FACC,
      S_ROW_NEXT, S_TMUL, S_TACC, S_T_NEXT, S_CORD_GO, S_CORD_WAIT, S_RMUL,
      S_RACC, S_K_NEXT, S_OUT
   } st_type;

   typedef struct packed {
      logic                      start;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_q30;
      logic signed [31:0] sin_q30;
   } cordic_rsp_type;

   function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
      unique case (i)
         5'd0:    return 33'sd843314857;
         5'd1:    return 33'sd497837829;
         5'd2:    return 33'sd263043837;
         5'd3:    return 33'sd133525159;
         5'd4:    return 33'sd67021687;
         5'd5:    return 33'sd33543516;
         5'd6:    return 33'sd16775851;
         5'd7:    return 33'sd8388437;
         5'd8:    return 33'sd4194283;
         5'd9:    return 33'sd2097149;
         5'd10:   return 33'sd1048576;
         5'd11:   return 33'sd524288;
         5'd12:   return 33'sd262144;
         5'd13:   return 33'sd131072;
         5'd14:   return 33'sd65536;
         5'd15:   return 33'sd32768;
         5'd16:   return 33'sd16384;
         5'd17:   return 33'sd8192;
         5'd18:   return 33'sd4096;
         5'd19:   return 33'sd2048;
         5'd20:   return 33'sd1024;
         5'd21:   return 33'sd512;
         5'd22:   return 33'sd256;
         5'd23:   return 33'sd128;
         default: return 33'sd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/core/djp_if.sv */
// Request and response channel interfaces of the dipole beam Jones block.
`timescale 1ns / 1ps
`default_nettype none
interface djp_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [1:0]         harmonic_index;
   logic [2:0]         theta_power;
   logic [2:0]         freq_power;
   logic signed [31:0] coef_x_re;
   logic signed [31:0] coef_x_im;
   logic signed [31:0] coef_y_re;
   logic signed [31:0] coef_y_im;
   logic [29:0]        frequency_hz;
   logic [22:0]        theta;
   logic signed [23:0] phi;

   modport source (output valid, operation, harmonic_index, theta_power, freq_power,
                   coef_x_re, coef_x_im, coef_y_re, coef_y_im, frequency_hz, theta, phi,
                   input ready);
   modport sink (input valid, operation, harmonic_index, theta_power, freq_power,
                 coef_x_re, coef_x_im, coef_y_re, coef_y_im, frequency_hz, theta, phi,
                 output ready);
endinterface

interface djp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] j00_re;
   logic signed [31:0] j00_im;
   logic signed [31:0] j01_re;
   logic signed [31:0] j01_im;
   logic signed [31:0] j10_re;
   logic signed [31:0] j10_im;
   logic signed [31:0] j11_re;
   logic signed [31:0] j11_im;

   modport source (output valid, j00_re, j00_im, j01_re, j01_im, j10_re, j10_im, j11_re,
                   j11_im, input ready);
   modport sink (input valid, j00_re, j00_im, j01_re, j01_im, j10_re, j10_im, j11_re,
                 j11_im, output ready);
endinterface
`default_nettype wire

/* rtl/core/djp_cordic.sv */
// Iterative angle reduction and 24-step CORDIC giving cos and sin in Q2.30.
`timescale 1ns / 1ps
`default_nettype none
module djp_cordic
   import djp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cordic_req_type creq,
   output      cordic_rsp_type crsp
);

   cr_state_type       state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [31:0] r_ff, r_in;
   logic               flip_ff, flip_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CR_IDLE, CR_DONE: if (creq.start) state_in = CR_REDUCE;
         CR_REDUCE:        if (cnt_ff == 5'd0) state_in = CR_FOLD;
         CR_FOLD:          state_in = CR_ROTATE;
         CR_ROTATE:        if (cnt_ff == 5'(CORDIC_STEPS - 1)) state_in = CR_DONE;
         default:          state_in = CR_IDLE;
      endcase
   end

   always_comb begin
      logic signed [31:0] tp, mag, rr;
      logic signed [33:0] dx, dy;
      logic               fl;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      tp      = TWO_PI_Q20 <<< cnt_ff;
      mag     = (r_ff < 0) ? -r_ff : r_ff;
      rr      = r_ff;
      fl      = 1'b0;
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      unique case (state_ff)
         CR_IDLE, CR_DONE: begin
            if (creq.start) begin
               r_in   = 32'(creq.angle);
               cnt_in = 5'(REDUCE_STEPS - 1);
            end
         end
         CR_REDUCE: begin
            // truncating remainder by 2*pi, one binary digit per cycle
            if (mag >= tp) r_in = (r_ff < 0) ? r_ff + tp : r_ff - tp;
            cnt_in = cnt_ff - 5'd1;
         end
         CR_FOLD: begin
            if (rr > PI_Q20) rr = rr - TWO_PI_Q20;
            if (rr < -PI_Q20) rr = rr + TWO_PI_Q20;
            if (rr > HALF_PI_Q20) begin
               rr = rr - PI_Q20;
               fl = 1'b1;
            end else if (rr < -HALF_PI_Q20) begin
               rr = rr + PI_Q20;
               fl = 1'b1;
            end
            z_in    = 33'(rr <<< 10);
            x_in    = CORDIC_START;
            y_in    = 34'sd0;
            flip_in = fl;
            cnt_in  = 5'd0;
         end
         CR_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_q30(cnt_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_q30(cnt_ff);
            end
            cnt_in = cnt_ff + 5'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      r_ff    <= r_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   always_comb begin
      crsp.done    = (state_ff == CR_DONE);
      crsp.cos_q30 = 32'(flip_ff ? -x_ff : x_ff);
      crsp.sin_q30 = 32'(flip_ff ? -y_ff : y_ff);
   end

endmodule
`default_nettype wire

/* rtl/core/dipole_beam_jones_polynomial.sv */
// Top level: coefficient store, sequencer, shared multiplier and Jones accumulators.
//
//   channel   dir  handshake     carries
//   req_chan  in   valid/ready   load entry or query direction
//   rsp_chan  out  valid/ready   one Jones matrix per query
//   csr_*     in   write enable  configuration registers
//
// One item at a time; req_chan.ready is high only while idle.
// A load writes the store directly. A query below the horizon goes straight to the output, as
// does one with zero harmonics after normalisation; otherwise the query time is set by the single
// 32x32 multiplier, shared by every product, and by the CORDIC wait per harmonic.
// Synchronous active-high reset clears control; the store holds no reset value.
// A result waits in the output until rsp_chan.ready, with the input held off.
`timescale 1ns / 1ps
`default_nettype none
module dipole_beam_jones_polynomial
   import djp_pkg::*;
#(
   parameter int MAX_HARMONICS   = 4,
   parameter int MAX_THETA_TERMS = 8,
   parameter int MAX_FREQ_TERMS  = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   djp_req_if.sink    req_chan,
   djp_rsp_if.source  rsp_chan,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   localparam int DEPTH = MAX_HARMONICS * MAX_THETA_TERMS * MAX_FREQ_TERMS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int TW    = (MAX_THETA_TERMS > 1) ? $clog2(MAX_THETA_TERMS) : 1;
   localparam int FW    = (MAX_FREQ_TERMS > 1) ? $clog2(MAX_FREQ_TERMS) : 1;
   localparam int NHW   = $clog2(MAX_HARMONICS + 1);
   localparam int NTW   = $clog2(MAX_THETA_TERMS + 1);
   localparam int NFW   = $clog2(MAX_FREQ_TERMS + 1);

   // configuration
   logic [2:0]  nh_cfg_ff;
   logic [3:0]  nt_cfg_ff, nf_cfg_ff;
   logic [29:0] center_ff;
   logic [47:0] inv_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nh_cfg_ff    <= 3'd2;
         nt_cfg_ff    <= 4'd5;
         nf_cfg_ff    <= 4'd5;
         center_ff    <= 30'd0;
         inv_range_ff <= 48'd0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_HARMONICS: nh_cfg_ff    <= csr_wdata[2:0];
            CSR_THETA_TERMS:   nt_cfg_ff    <= csr_wdata[3:0];
            CSR_FREQ_TERMS:    nf_cfg_ff    <= csr_wdata[3:0];
            CSR_FREQ_CENTER:   center_ff    <= csr_wdata[29:0];
            CSR_INV_RANGE:     inv_range_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [NHW-1:0] nh_eff;
   logic [NTW-1:0] nt_eff;
   logic [NFW-1:0] nf_eff;

   always_comb begin
      nh_eff = (int'(nh_cfg_ff) > MAX_HARMONICS) ? NHW'(MAX_HARMONICS) : NHW'(nh_cfg_ff);
      if (nt_cfg_ff == 4'd0) nt_eff = NTW'(1);
      else if (int'(nt_cfg_ff) > MAX_THETA_TERMS) nt_eff = NTW'(MAX_THETA_TERMS);
      else nt_eff = NTW'(nt_cfg_ff);
      if (nf_cfg_ff == 4'd0) nf_eff = NFW'(1);
      else if (int'(nf_cfg_ff) > MAX_FREQ_TERMS) nf_eff = NFW'(MAX_FREQ_TERMS);
      else nf_eff = NFW'(nf_cfg_ff);
   end

   // sequencer and datapath registers
   st_type             state_ff, state_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [FW-1:0]      i_ff, i_in;
   logic [2:0]         lane_ff, lane_in;
   logic signed [39:0] acc_ff [8];
   logic signed [39:0] acc_in [8];
   logic signed [31:0] p_ff [4];
   logic signed [31:0] p_in [4];
   logic signed [31:0] q_ff [4];
   logic signed [31:0] q_in [4];
   logic signed [31:0] fn_ff, fn_in;
   logic [22:0]        th_ff, th_in;
   logic signed [23:0] phi_ff, phi_in;
   logic signed [29:0] ang_ff, ang_in;
   logic [29:0]        m_ff, m_in;
   logic               neg_ff, neg_in;
   logic [63:0]        a_ff, a_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;
   logic [127:0]       rd_ff;
   logic [127:0]       mem [DEPTH];

   cordic_req_type creq;
   cordic_rsp_type crsp;

   logic req_acc, rsp_acc, load_we, last_i, last_t;
   logic [AW-1:0] wr_addr, rd_addr;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;
   assign last_i  = (int'(i_ff) == int'(nf_eff) - 1);
   assign last_t  = (int'(t_ff) == int'(nt_eff) - 1);

   assign load_we = req_acc && (req_chan.operation == OP_LOAD) &&
                    (int'(req_chan.harmonic_index) < MAX_HARMONICS) &&
                    (int'(req_chan.theta_power) < MAX_THETA_TERMS) &&
                    (int'(req_chan.freq_power) < MAX_FREQ_TERMS);
   assign wr_addr = AW'((int'(req_chan.harmonic_index) * MAX_THETA_TERMS +
                         int'(req_chan.theta_power)) * MAX_FREQ_TERMS +
                        int'(req_chan.freq_power));
   assign rd_addr = AW'((int'(k_ff) * MAX_THETA_TERMS + int'(t_ff)) * MAX_FREQ_TERMS +
                        int'(i_ff));

   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[wr_addr] <= {req_chan.coef_x_re, req_chan.coef_x_im,
                          req_chan.coef_y_re, req_chan.coef_y_im};
      end
      if (state_ff == S_ROW_RD) rd_ff <= mem[rd_addr];
   end

   function automatic logic signed [31:0] coef_lane(input logic [127:0] row,
                                                    input logic [1:0] l);
      return row[127 - 32*int'(l) -: 32];
   endfunction

   function automatic logic signed [31:0] hstep(input logic signed [63:0] prod,
                                                input logic signed [31:0] c);
      return sat32((prod >>> 20) + 64'(c));
   endfunction

   // shared multiplier operand select
   always_comb begin
      mul_a = 32'sd0;
      mul_b = 32'sd0;
      unique case (state_ff)
         S_NORM_A: begin
            mul_a = 32'({2'b00, m_ff});
            mul_b = 32'({8'd0, inv_range_ff[47:24]});
         end
         S_NORM_B: begin
            mul_a = 32'({2'b00, m_ff});
            mul_b = 32'({8'd0, inv_range_ff[23:0]});
         end
         S_FMUL: begin
            mul_a = q_ff[lane_ff[1:0]];
            mul_b = fn_ff;
         end
         S_TMUL: begin
            mul_a = p_ff[lane_ff[1:0]];
            mul_b = 32'({9'd0, th_ff});
         end
         S_RMUL: begin
            mul_a = p_ff[lane_ff[1:0]];
            // lanes 2..5 take sin, the rest cos
            mul_b = (lane_ff == 3'd2 || lane_ff == 3'd3 || lane_ff == 3'd4 ||
                     lane_ff == 3'd5) ? crsp.sin_q30 : crsp.cos_q30;
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_chan.operation == OP_EVAL) begin
               state_in = (req_chan.theta >= HALF_PI_LIMIT) ? S_OUT : S_NORM_A;
            end
         end
         S_NORM_A:    state_in = S_NORM_B;
         S_NORM_B:    state_in = S_NORM_C;
         S_NORM_C:    state_in = (nh_eff == '0) ? S_OUT : S_ROW_RD;
         S_ROW_RD:    state_in = S_ROW_DAT;
         S_ROW_DAT:   state_in = last_i ? S_ROW_NEXT : S_FMUL;
         S_FMUL:      state_in = S_FACC;
         S_FACC:      state_in = (lane_ff == 3'd3) ? S_ROW_NEXT : S_FMUL;
         S_ROW_NEXT: begin
            if (i_ff != '0) state_in = S_ROW_RD;
            else state_in = last_t ? S_T_NEXT : S_TMUL;
         end
         S_TMUL:      state_in = S_TACC;
         S_TACC:      state_in = (lane_ff == 3'd3) ? S_T_NEXT : S_TMUL;
         S_T_NEXT:    state_in = (t_ff == '0) ? S_CORD_GO : S_ROW_RD;
         S_CORD_GO:   state_in = S_CORD_WAIT;
         S_CORD_WAIT: if (crsp.done) state_in = S_RMUL;
         S_RMUL:      state_in = S_RACC;
         S_RACC:      state_in = (lane_ff == 3'd7) ? S_K_NEXT : S_RMUL;
         S_K_NEXT:    state_in = (int'(k_ff) == int'(nh_eff) - 1) ? S_OUT : S_ROW_RD;
         S_OUT:       if (rsp_acc) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      logic signed [30:0] d;
      logic [63:0]        q;
      logic signed [63:0] term;
      k_in    = k_ff;
      t_in    = t_ff;
      i_in    = i_ff;
      lane_in = lane_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      fn_in   = fn_ff;
      th_in   = th_ff;
      phi_in  = phi_ff;
      ang_in  = ang_ff;
      m_in    = m_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      d       = 31'(signed'({1'b0, req_chan.frequency_hz})) -
                31'(signed'({1'b0, center_ff}));
      q       = (a_ff >> 4) + (((64'(a_ff[3:0]) << 24) + 64'(prod_ff)) >> 28);
      term    = prod_ff >>> 30;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && req_chan.operation == OP_EVAL) begin
               for (int n = 0; n < 8; n++) acc_in[n] = 40'sd0;
               k_in   = '0;
               th_in  = req_chan.theta;
               phi_in = req_chan.phi;
               ang_in = 30'(req_chan.phi);
               neg_in = (d < 0);
               m_in   = 30'((d < 0) ? -d : d);
            end
         end
         S_NORM_B: a_in = 64'(prod_ff);
         S_NORM_C: begin
            if (q > 64'h7fffffff) fn_in = neg_ff ? 32'sh80000000 : 32'sh7fffffff;
            else fn_in = neg_ff ? -signed'(q[31:0]) : signed'(q[31:0]);
            t_in = TW'(int'(nt_eff) - 1);
            i_in = FW'(int'(nf_eff) - 1);
         end
         S_ROW_DAT: begin
            if (last_i) begin
               for (int l = 0; l < 4; l++) q_in[l] = coef_lane(rd_ff, 2'(l));
            end
            lane_in = 3'd0;
         end
         S_FACC: begin
            q_in[lane_ff[1:0]] = hstep(prod_ff, coef_lane(rd_ff, lane_ff[1:0]));
            lane_in = lane_ff + 3'd1;
         end
         S_ROW_NEXT: begin
            if (i_ff != '0) begin
               i_in = i_ff - FW'(1);
            end else if (last_t) begin
               p_in = q_ff;
            end
            lane_in = 3'd0;
         end
         S_TACC: begin
            p_in[lane_ff[1:0]] = hstep(prod_ff, q_ff[lane_ff[1:0]]);
            lane_in = lane_ff + 3'd1;
         end
         S_T_NEXT: begin
            if (t_ff != '0) begin
               t_in = t_ff - TW'(1);
               i_in = FW'(int'(nf_eff) - 1);
            end
         end
         S_CORD_WAIT: lane_in = 3'd0;
         S_RACC: begin
            // cross terms of y with sin enter negated
            if (lane_ff == 3'd2 || lane_ff == 3'd3) acc_in[lane_ff] = acc_ff[lane_ff] - 40'(term);
            else acc_in[lane_ff] = acc_ff[lane_ff] + 40'(term);
            lane_in = lane_ff + 3'd1;
         end
         S_K_NEXT: begin
            k_in   = k_ff + KW'(1);
            ang_in = ang_ff + (30'(phi_ff) <<< 1);
            t_in   = TW'(int'(nt_eff) - 1);
            i_in   = FW'(int'(nf_eff) - 1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      t_ff    <= t_in;
      i_ff    <= i_in;
      lane_ff <= lane_in;
      acc_ff  <= acc_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      fn_ff   <= fn_in;
      th_ff   <= th_in;
      phi_ff  <= phi_in;
      ang_ff  <= ang_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      creq.start = (state_ff == S_CORD_GO);
      creq.angle = k_ff[0] ? -ang_ff : ang_ff;
   end

   djp_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .creq  (creq),
      .crsp  (crsp)
   );

   always_comb begin
      req_chan.ready  = (state_ff == S_IDLE);
      rsp_chan.valid  = (state_ff == S_OUT);
      rsp_chan.j00_re = sat32(64'(acc_ff[0]));
      rsp_chan.j00_im = sat32(64'(acc_ff[1]));
      rsp_chan.j01_re = sat32(64'(acc_ff[2]));
      rsp_chan.j01_im = sat32(64'(acc_ff[3]));
      rsp_chan.j10_re = sat32(64'(acc_ff[4]));
      rsp_chan.j10_im = sat32(64'(acc_ff[5]));
      rsp_chan.j11_re = sat32(64'(acc_ff[6]));
      rsp_chan.j11_im = sat32(64'(acc_ff[7]));
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input taken while a result is pending");

   a_horizon: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.operation == OP_EVAL && req_chan.theta >= HALF_PI_LIMIT)
      |=> rsp_chan.valid)
      else $error("below-horizon query did not answer at once");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.operation == OP_LOAD) |=> req_chan.ready)
      else $error("load held the block busy");

endmodule
`default_nettype wire
